// ===== rtl/npflm_pkg.sv =====
// Shared types, constants and command structures for the node pool free-list manager.
package npflm_pkg;

	localparam int POOL_NODES_DEF = 64;
	localparam int NODE_W = 6;
	localparam int LINK_W = 7;
	localparam int CNT_W = 7;
	localparam int MASK_W = 64;
	localparam int OP_W = 2;
	localparam int STATUS_W = 2;

	localparam logic [LINK_W-1:0] NIL_LINK = 7'd64;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC  = 2'd0,
		OP_FILTER = 2'd1,
		OP_WALK   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC,
		S_FILT,
		S_LINK,
		S_WALK
	} state_t;

	typedef enum logic [1:0] {
		SRC_FREE_HEAD,
		SRC_USED_HEAD,
		SRC_LINK
	} ptr_src_t;

	typedef struct packed {
		logic     load_mask;
		logic     init;
		logic     p_load;
		logic     rd_en;
		ptr_src_t src;
		logic     cnt_inc;
		logic     alloc_commit;
		logic     filter_eval;
		logic     link_fix;
		logic     emit;
		status_t  emit_status;
		logic     emit_node;
		logic     emit_last;
	} dp_cmd_t;

	typedef struct packed {
		logic free_nil;
		logic used_nil;
		logic keep;
		logic prev_nil;
		logic nxt_more;
		logic more_now;
	} dp_sts_t;

endpackage

// ===== rtl/node_pool_free_list_manager_top.sv =====
// Top level of the node pool free-list manager: controller, datapath and assertions.
// A transaction is taken when start is high while busy is low, and its results appear one per
// cycle on the result ports, each marked by strobe for a single cycle; the receiver cannot stall
// them, so it must take every strobed result. Allocate reads the free head, then commits the
// node and gives its result in the cycle after. Filter reads the head, then visits each
// allocated node in turn, keeping it or unlinking it, with an extra link-fix step for a node
// unlinked from behind a kept node; the first node is never unlinked from behind a kept one.
// Walk reads the head, then gives one result per cycle. These steps are set by the link store,
// a RAM with one read and one write port and registered read data. Commands on empty lists,
// a full pool and unused codes finish in the cycle they are taken and their result follows in
// the next cycle.
module node_pool_free_list_manager_top
	import npflm_pkg::*;
#(
	parameter int POOL_NODES = POOL_NODES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [OP_W-1:0]     operation,
	input  logic [MASK_W-1:0]   keep_mask,
	output logic                strobe,
	output logic [STATUS_W-1:0] status,
	output logic [NODE_W-1:0]   node_index,
	output logic                last,
	output logic [CNT_W-1:0]    free_count,
	output logic [CNT_W-1:0]    allocated_count
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	npflm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.operation(operation),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	npflm_dp #(
		.POOL_NODES(POOL_NODES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.keep_mask      (keep_mask),
		.cmd            (cmd),
		.sts            (sts),
		.strobe         (strobe),
		.status         (status),
		.node_index     (node_index),
		.last           (last),
		.free_count     (free_count),
		.allocated_count(allocated_count)
	);

`ifndef NO_ASSERTIONS
	a_counts_conserved: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ((free_count + allocated_count) == CNT_W'(POOL_NODES)))
		else $error("free and allocated counts do not add up to the pool size");

	a_full_means_no_free: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status == STATUS_FULL) |-> (free_count == '0))
		else $error("pool full reported while free nodes remain");

	a_empty_means_no_used: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status == STATUS_EMPTY) |-> (allocated_count == '0))
		else $error("empty walk reported while nodes are allocated");

	a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (strobe && last))
		else $error("transaction finished without a final result");
`endif

endmodule

// ===== rtl/npflm_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module npflm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/npflm_ctrl.sv =====
// Controller state machine that sequences allocate, filter and walk transactions.
module npflm_ctrl
	import npflm_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [OP_W-1:0] operation,
	input  dp_sts_t         sts,
	output dp_cmd_t         cmd,
	output logic            busy
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.src = SRC_LINK;
		cmd.emit_status = STATUS_OK;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load_mask = 1'b1;
					case (op_t'(operation))
						OP_ALLOC: begin
							if (sts.free_nil) begin
								cmd.emit = 1'b1;
								cmd.emit_status = STATUS_FULL;
								cmd.emit_last = 1'b1;
							end else begin
								cmd.src = SRC_FREE_HEAD;
								cmd.rd_en = 1'b1;
								cmd.p_load = 1'b1;
								state_d = S_ALLOC;
							end
						end
						OP_FILTER: begin
							if (sts.used_nil) begin
								cmd.emit = 1'b1;
								cmd.emit_last = 1'b1;
							end else begin
								cmd.src = SRC_USED_HEAD;
								cmd.rd_en = 1'b1;
								cmd.p_load = 1'b1;
								cmd.init = 1'b1;
								state_d = S_FILT;
							end
						end
						OP_WALK: begin
							if (sts.used_nil) begin
								cmd.emit = 1'b1;
								cmd.emit_status = STATUS_EMPTY;
								cmd.emit_last = 1'b1;
							end else begin
								cmd.src = SRC_USED_HEAD;
								cmd.rd_en = 1'b1;
								cmd.p_load = 1'b1;
								cmd.init = 1'b1;
								state_d = S_WALK;
							end
						end
						default: begin
							cmd.emit = 1'b1;
							cmd.emit_last = 1'b1;
						end
					endcase
				end
			end
			S_ALLOC: begin
				cmd.alloc_commit = 1'b1;
				cmd.emit = 1'b1;
				cmd.emit_node = 1'b1;
				cmd.emit_last = 1'b1;
				state_d = S_IDLE;
			end
			S_FILT: begin
				cmd.filter_eval = 1'b1;
				cmd.cnt_inc = 1'b1;
				cmd.p_load = 1'b1;
				cmd.rd_en = sts.nxt_more;
				if (!sts.keep && !sts.prev_nil) begin
					state_d = S_LINK;
				end else if (sts.nxt_more) begin
					state_d = S_FILT;
				end else begin
					cmd.emit = 1'b1;
					cmd.emit_last = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_LINK: begin
				cmd.link_fix = 1'b1;
				if (sts.more_now) begin
					state_d = S_FILT;
				end else begin
					cmd.emit = 1'b1;
					cmd.emit_last = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_WALK: begin
				cmd.emit = 1'b1;
				cmd.emit_node = 1'b1;
				cmd.emit_last = !sts.nxt_more;
				cmd.cnt_inc = 1'b1;
				cmd.p_load = 1'b1;
				cmd.rd_en = sts.nxt_more;
				state_d = sts.nxt_more ? S_WALK : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== rtl/npflm_dp.sv =====
// Datapath holding the list heads, counts, link store and result registers.
module npflm_dp
	import npflm_pkg::*;
#(
	parameter int POOL_NODES = POOL_NODES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [MASK_W-1:0]   keep_mask,
	input  dp_cmd_t             cmd,
	output dp_sts_t             sts,
	output logic                strobe,
	output logic [STATUS_W-1:0] status,
	output logic [NODE_W-1:0]   node_index,
	output logic                last,
	output logic [CNT_W-1:0]    free_count,
	output logic [CNT_W-1:0]    allocated_count
);

	localparam int AW = $clog2(POOL_NODES);
	localparam logic [CNT_W:0] POOL_WIDE = (CNT_W+1)'(POOL_NODES);
	localparam logic [CNT_W-1:0] POOL_CNT = CNT_W'(POOL_NODES);

	logic [LINK_W-1:0] free_head_q;
	logic [LINK_W-1:0] used_head_q;
	logic [CNT_W-1:0]  free_total_q;
	logic [CNT_W-1:0]  used_total_q;
	logic [LINK_W-1:0] p_q;
	logic [LINK_W-1:0] prev_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [MASK_W-1:0] mask_q;
	logic [POOL_NODES-1:0] valid_q;

	logic [AW-1:0]     raddr_s1;
	logic              vld_s1;

	status_t           status_q;
	logic [NODE_W-1:0] node_q;
	logic              last_q;
	logic [CNT_W-1:0]  free_cnt_q;
	logic [CNT_W-1:0]  used_cnt_q;
	logic              strobe_q;

	logic [LINK_W-1:0] rdata;
	logic [LINK_W-1:0] lnk;
	logic [LINK_W-1:0] ptr_next;
	logic [AW-1:0]     raddr;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [LINK_W-1:0] wdata;
	logic              keep;
	logic              drop;
	logic [CNT_W-1:0]  free_d;
	logic [CNT_W-1:0]  used_d;

	function automatic logic [LINK_W-1:0] reset_link(input logic [AW-1:0] a);
		logic [LINK_W:0] n;
		n = (LINK_W+1)'(a) + 1'b1;
		if (n < (LINK_W+1)'(POOL_NODES)) begin
			return LINK_W'(n);
		end
		return NIL_LINK;
	endfunction

	// Entries never written since reset read as their reset link.
	assign lnk = vld_s1 ? rdata : reset_link(raddr_s1);

	always_comb begin
		case (cmd.src)
			SRC_FREE_HEAD: ptr_next = free_head_q;
			SRC_USED_HEAD: ptr_next = used_head_q;
			SRC_LINK:      ptr_next = lnk;
			default:       ptr_next = lnk;
		endcase
	end

	assign raddr = ptr_next[AW-1:0];
	assign keep  = mask_q[p_q[NODE_W-1:0]];
	assign drop  = cmd.filter_eval & ~keep;

	assign we    = cmd.alloc_commit | drop | cmd.link_fix;
	assign waddr = cmd.link_fix ? prev_q[AW-1:0] : p_q[AW-1:0];

	always_comb begin
		if (cmd.alloc_commit) begin
			wdata = used_head_q;
		end else if (drop) begin
			wdata = free_head_q;
		end else begin
			wdata = p_q;
		end
	end

	always_comb begin
		free_d = free_total_q;
		used_d = used_total_q;
		if (cmd.alloc_commit) begin
			free_d = free_total_q - 1'b1;
			used_d = used_total_q + 1'b1;
		end else if (drop) begin
			free_d = free_total_q + 1'b1;
			used_d = used_total_q - 1'b1;
		end
	end

	npflm_ram #(
		.WIDTH(LINK_W),
		.DEPTH(POOL_NODES)
	) u_link_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q  <= '0;
			used_head_q  <= NIL_LINK;
			free_total_q <= POOL_CNT;
			used_total_q <= '0;
			valid_q      <= '0;
			strobe_q     <= 1'b0;
		end else begin
			if (cmd.alloc_commit) begin
				free_head_q <= lnk;
				used_head_q <= p_q;
			end else if (drop) begin
				free_head_q <= p_q;
				if (prev_q == NIL_LINK) begin
					used_head_q <= lnk;
				end
			end
			free_total_q <= free_d;
			used_total_q <= used_d;
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			strobe_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_mask) begin
			mask_q <= keep_mask;
		end
		if (cmd.p_load) begin
			p_q <= ptr_next;
		end
		if (cmd.init) begin
			prev_q <= NIL_LINK;
		end else if (cmd.filter_eval && keep) begin
			prev_q <= p_q;
		end
		if (cmd.init) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.rd_en) begin
			raddr_s1 <= raddr;
			vld_s1   <= valid_q[raddr];
		end
		if (cmd.emit) begin
			status_q   <= cmd.emit_status;
			node_q     <= cmd.emit_node ? p_q[NODE_W-1:0] : '0;
			last_q     <= cmd.emit_last;
			free_cnt_q <= free_d;
			used_cnt_q <= used_d;
		end
	end

	assign sts.free_nil = (free_head_q == NIL_LINK);
	assign sts.used_nil = (used_head_q == NIL_LINK);
	assign sts.keep     = keep;
	assign sts.prev_nil = (prev_q == NIL_LINK);
	assign sts.nxt_more = (lnk != NIL_LINK) && (((CNT_W+1)'(cnt_q) + 1'b1) < POOL_WIDE);
	assign sts.more_now = (p_q != NIL_LINK) && (cnt_q < POOL_CNT);

	assign strobe          = strobe_q;
	assign status          = status_q;
	assign node_index      = node_q;
	assign last            = last_q;
	assign free_count      = free_cnt_q;
	assign allocated_count = used_cnt_q;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the node pool free-list manager, with directed and random commands.
module tb_top
	import npflm_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int POOL = POOL_NODES_DEF;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 2 * POOL + 8;
	localparam int RANDOM_ITEMS = 200;
	localparam logic [MASK_W-1:0] ALL_ONES = {MASK_W{1'b1}};

	typedef struct packed {
		status_t           status;
		logic [NODE_W-1:0] node;
		logic              last;
		logic [CNT_W-1:0]  free_cnt;
		logic [CNT_W-1:0]  used_cnt;
	} pool_result_t;

	typedef struct {
		op_t               op;
		logic [MASK_W-1:0] mask;
		int                repeats;
		logic              typed;
		pool_result_t      want;
	} cmd_row_t;

	localparam pool_result_t NOT_TYPED = '0;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [OP_W-1:0]    operation = OP_NONE;
	logic [MASK_W-1:0]  keep_mask = '0;
	logic               busy;
	logic               strobe;
	logic [STATUS_W-1:0] status;
	logic [NODE_W-1:0]  node_index;
	logic               last;
	logic [CNT_W-1:0]   free_count;
	logic [CNT_W-1:0]   allocated_count;

	logic               row_typed = 1'b0;
	pool_result_t       row_want = NOT_TYPED;

	logic [LINK_W-1:0]  pool_link [POOL];
	logic [LINK_W-1:0]  pool_free_head;
	logic [LINK_W-1:0]  pool_used_head;
	logic [CNT_W-1:0]   pool_free_total;
	logic [CNT_W-1:0]   pool_used_total;

	pool_result_t       pending_results [$];
	int                 mismatches = 0;
	int                 quiet_cycles = 0;
	int                 issued_items = 0;
	logic               steady_run = 1'b0;

	cmd_row_t           script [20];

	node_pool_free_list_manager_top #(
		.POOL_NODES(POOL)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.keep_mask(keep_mask),
		.strobe(strobe),
		.status(status),
		.node_index(node_index),
		.last(last),
		.free_count(free_count),
		.allocated_count(allocated_count)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic void queue_result(input status_t st, input logic [NODE_W-1:0] node,
			input logic fin);
		pool_result_t r;
		r.status = st;
		r.node = node;
		r.last = fin;
		r.free_cnt = pool_free_total;
		r.used_cnt = pool_used_total;
		pending_results.push_back(r);
	endfunction

	function automatic void pool_reset();
		for (int i = 0; i < POOL; i++) begin
			pool_link[i] = (i + 1 < POOL) ? LINK_W'(i + 1) : NIL_LINK;
		end
		pool_free_head = '0;
		pool_used_head = NIL_LINK;
		pool_free_total = CNT_W'(POOL);
		pool_used_total = '0;
	endfunction

	function automatic void pool_apply(input op_t op, input logic [MASK_W-1:0] mask);
		logic [LINK_W-1:0] prev;
		logic [LINK_W-1:0] cur;
		logic [LINK_W-1:0] nxt;
		int visits;
		prev = NIL_LINK;
		cur = NIL_LINK;
		visits = 0;
		case (op)
			OP_ALLOC: begin
				if (pool_free_head == NIL_LINK) begin
					queue_result(STATUS_FULL, '0, 1'b1);
				end else begin
					cur = pool_free_head;
					pool_free_head = pool_link[cur[NODE_W-1:0]];
					pool_link[cur[NODE_W-1:0]] = pool_used_head;
					pool_used_head = cur;
					pool_free_total = pool_free_total - 1'b1;
					pool_used_total = pool_used_total + 1'b1;
					queue_result(STATUS_OK, cur[NODE_W-1:0], 1'b1);
				end
			end
			OP_FILTER: begin
				cur = pool_used_head;
				while (cur != NIL_LINK && visits < POOL) begin
					nxt = pool_link[cur[NODE_W-1:0]];
					if (cur < POOL && mask[cur[NODE_W-1:0]]) begin
						prev = cur;
					end else begin
						if (prev == NIL_LINK)
							pool_used_head = nxt;
						else
							pool_link[prev[NODE_W-1:0]] = nxt;
						pool_link[cur[NODE_W-1:0]] = pool_free_head;
						pool_free_head = cur;
						pool_free_total = pool_free_total + 1'b1;
						pool_used_total = pool_used_total - 1'b1;
					end
					cur = nxt;
					visits++;
				end
				queue_result(STATUS_OK, '0, 1'b1);
			end
			OP_WALK: begin
				cur = pool_used_head;
				if (cur == NIL_LINK)
					queue_result(STATUS_EMPTY, '0, 1'b1);
				while (cur != NIL_LINK && visits < POOL) begin
					nxt = pool_link[cur[NODE_W-1:0]];
					queue_result(STATUS_OK, cur[NODE_W-1:0], nxt == NIL_LINK || visits + 1 >= POOL);
					cur = nxt;
					visits++;
				end
			end
			default: begin
				queue_result(STATUS_OK, '0, 1'b1);
			end
		endcase
	endfunction

	function automatic logic [MASK_W-1:0] random_mask();
		logic [MASK_W-1:0] a;
		logic [MASK_W-1:0] b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: return a & b;
			1: return a | b;
			2: return ALL_ONES;
			3: return '0;
			default: return a;
		endcase
	endfunction

	always @(posedge clk) begin : result_monitor
		pool_result_t want;
		if (arst_n) begin
			if (strobe) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result: status %0d, node_index %0d", status, node_index);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						mismatches++;
					end
					if (node_index !== want.node) begin
						$error("node_index: expected %0d, got %0d", want.node, node_index);
						mismatches++;
					end
					if (last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, last);
						mismatches++;
					end
					if (free_count !== want.free_cnt) begin
						$error("free_count: expected %0d, got %0d", want.free_cnt, free_count);
						mismatches++;
					end
					if (allocated_count !== want.used_cnt) begin
						$error("allocated_count: expected %0d, got %0d", want.used_cnt,
							allocated_count);
						mismatches++;
					end
				end
			end
			if (start && !busy) begin
				pool_apply(op_t'(operation), keep_mask);
				if (row_typed)
					pending_results[pending_results.size() - 1] = row_want;
			end
			if (strobe || (start && !busy))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task automatic issue_command(input op_t op, input logic [MASK_W-1:0] mask,
			input logic typed, input pool_result_t want);
		int gap;
		if (issued_items % 32 == 0)
			steady_run = ($urandom_range(0, 3) == 0);
		issued_items++;
		gap = steady_run ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		keep_mask <= mask;
		row_typed <= typed;
		row_want <= want;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	initial begin
		int sent;
		int burst;
		op_t op;
		sent = 0;
		burst = 0;
		op = OP_NONE;
		pool_reset();
		script = '{
			'{OP_WALK,   '0,   1, 1'b1, '{STATUS_EMPTY, 6'd0, 1'b1, 7'd64, 7'd0}},
			'{OP_FILTER, '0,   1, 1'b1, '{STATUS_OK,    6'd0, 1'b1, 7'd64, 7'd0}},
			'{OP_NONE,   ALL_ONES, 1, 1'b1, '{STATUS_OK, 6'd0, 1'b1, 7'd64, 7'd0}},
			'{OP_ALLOC,  '0,   1, 1'b1, '{STATUS_OK,    6'd0, 1'b1, 7'd63, 7'd1}},
			'{OP_ALLOC,  ALL_ONES, 1, 1'b1, '{STATUS_OK, 6'd1, 1'b1, 7'd62, 7'd2}},
			'{OP_ALLOC,  '0,   1, 1'b1, '{STATUS_OK,    6'd2, 1'b1, 7'd61, 7'd3}},
			'{OP_WALK,   '0,   1, 1'b0, NOT_TYPED},
			'{OP_FILTER, 64'h2, 1, 1'b0, NOT_TYPED},
			'{OP_WALK,   '0,   1, 1'b0, NOT_TYPED},
			'{OP_ALLOC,  '0,  63, 1'b0, NOT_TYPED},
			'{OP_ALLOC,  '0,   1, 1'b1, '{STATUS_FULL,  6'd0, 1'b1, 7'd0, 7'd64}},
			'{OP_WALK,   ALL_ONES, 1, 1'b0, NOT_TYPED},
			'{OP_FILTER, ALL_ONES, 1, 1'b1, '{STATUS_OK, 6'd0, 1'b1, 7'd0, 7'd64}},
			'{OP_FILTER, 64'hAAAA_AAAA_AAAA_AAAA, 1, 1'b0, NOT_TYPED},
			'{OP_WALK,   '0,   1, 1'b0, NOT_TYPED},
			'{OP_FILTER, 64'h5555_5555_5555_5555, 1, 1'b1,
				'{STATUS_OK, 6'd0, 1'b1, 7'd64, 7'd0}},
			'{OP_WALK,   '0,   1, 1'b1, '{STATUS_EMPTY, 6'd0, 1'b1, 7'd64, 7'd0}},
			'{OP_ALLOC,  ALL_ONES, 1, 1'b0, NOT_TYPED},
			'{OP_NONE,   '0,   1, 1'b0, NOT_TYPED},
			'{OP_FILTER, '0,   1, 1'b0, NOT_TYPED}
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			repeat (script[i].repeats)
				issue_command(script[i].op, script[i].mask, script[i].typed, script[i].want);
		end

		// Allocation bursts keep the list long enough for filters and walks to do real work.
		while (sent < RANDOM_ITEMS) begin
			if (burst > 0) begin
				op = OP_ALLOC;
				burst--;
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2: op = OP_ALLOC;
					3: begin
						op = OP_ALLOC;
						burst = ($urandom_range(0, 3) == 0) ? 70 : $urandom_range(1, 20);
					end
					4, 5: op = OP_FILTER;
					6, 7, 8: op = OP_WALK;
					default: op = OP_NONE;
				endcase
			end
			issue_command(op, random_mask(), 1'b0, NOT_TYPED);
			sent++;
		end
		start <= 1'b0;

		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
